@@ sv/button_mode_led_blink_pwm_core_defines.svh @@
// Assertion macros used by the checker file of the LED pattern block.
`ifndef BUTTON_MODE_LED_BLINK_PWM_CORE_DEFINES_SVH
`define BUTTON_MODE_LED_BLINK_PWM_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define BMLB_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bmlb assertion failed");

// Next-cycle implication, disabled while reset is high.
`define BMLB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bmlb assertion failed");

`endif

@@ sv/bmlb_pkg.sv @@
// Package: types, register codes and reset values of the LED pattern block.
package bmlb_pkg;

   localparam int NUM_DUTY_LEVELS_DEF = 5;
   localparam int NUM_BLINK_MODES_DEF = 4;

   localparam int CNT_W       = 16;
   localparam int MODE_W      = 2;
   localparam int DUTY_OUT_W  = 3;
   localparam int PERIOD_W    = 8;
   localparam int STEP_W      = 6;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int NUM_HALF    = 4;

   localparam logic [CNT_W-1:0] SAMPLE_INTERVAL_RST = 16'd100;
   localparam logic [CNT_W-1:0] ASYM_TOTAL_RST      = 16'd2000;
   localparam logic [CNT_W-1:0] ASYM_PHASE_RST      = 16'd500;
   localparam logic [PERIOD_W-1:0] PWM_PERIOD_RST   = 8'd20;
   localparam logic [STEP_W-1:0] DUTY_STEP_RST      = 6'd5;
   localparam logic [CNT_W-1:0] HALF_PERIOD_RST [NUM_HALF] =
      '{16'd1000, 16'd500, 16'd250, 16'd166};

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SAMPLE_INTERVAL = 3'd0,
      REG_HALF_PERIOD_0   = 3'd1,
      REG_HALF_PERIOD_1   = 3'd2,
      REG_HALF_PERIOD_2   = 3'd3,
      REG_HALF_PERIOD_3   = 3'd4,
      REG_ASYM_TOTAL      = 3'd5,
      REG_PWM_PERIOD      = 3'd6,
      REG_DUTY_STEP       = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [CNT_W-1:0]    sample_interval;
      logic [CNT_W-1:0]    half_period_0;
      logic [CNT_W-1:0]    half_period_1;
      logic [CNT_W-1:0]    half_period_2;
      logic [CNT_W-1:0]    half_period_3;
      logic [CNT_W-1:0]    asym_total;
      logic [PERIOD_W-1:0] pwm_period;
      logic [STEP_W-1:0]   duty_step;
   } cfg_type;

   typedef struct packed {
      logic                  led_blink;
      logic                  led_steady;
      logic                  led_asym;
      logic                  led_pwm;
      logic [MODE_W-1:0]     blink_mode;
      logic [DUTY_OUT_W-1:0] duty_level;
   } rsp_type;

endpackage

@@ sv/bmlb_if.sv @@
// Channel interfaces: button tick requests and LED level responses.
interface bmlb_req_if;
   logic valid;
   logic ready;
   logic button_a;
   logic button_b;
   logic button_c;
   logic button_d;

   modport source (output valid, output button_a, output button_b,
                   output button_c, output button_d, input ready);
   modport sink   (input valid, input button_a, input button_b,
                   input button_c, input button_d, output ready);
endinterface

interface bmlb_rsp_if;
   logic       valid;
   logic       ready;
   logic       led_blink;
   logic       led_steady;
   logic       led_asym;
   logic       led_pwm;
   logic [1:0] blink_mode;
   logic [2:0] duty_level;

   modport source (output valid, output led_blink, output led_steady, output led_asym,
                   output led_pwm, output blink_mode, output duty_level, input ready);
   modport sink   (input valid, input led_blink, input led_steady, input led_asym,
                   input led_pwm, input blink_mode, input duty_level, output ready);
endinterface

@@ sv/button_mode_led_blink_pwm_core.sv @@
// Button-driven LED pattern block: one request beat per millisecond tick.
//
// req_ch carries the four button levels of one tick; rsp_ch returns the four
// LED levels, the blink mode and the PWM duty level after that tick.
// csr_we/csr_index/csr_wdata write the configuration registers
// (sample interval, four blink half periods, asymmetric total, PWM period,
// duty step); write them only while no beat is in flight.
// A request accepted at a clock edge is shown on rsp_ch from that edge
// onward, i.e. the response is valid in the cycle after acceptance.
// Throughput: one tick per clock cycle while responses are taken; the state update is a single
// registered pass of counter increments, one small multiply and compares.
// The response register is the state register: while a response waits
// with rsp ready low, req_ch.ready is low and the state holds. A response
// taken in the same cycle frees the slot for the next request.
// Reset (synchronous, active high) restores all registers to their
// defaults, clears the response valid and sets the sampled buttons to ones.
module button_mode_led_blink_pwm_core #(
   parameter int NUM_DUTY_LEVELS = bmlb_pkg::NUM_DUTY_LEVELS_DEF,
   parameter int NUM_BLINK_MODES = bmlb_pkg::NUM_BLINK_MODES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   bmlb_req_if.sink                        req_ch,
   bmlb_rsp_if.source                      rsp_ch,
   input  logic                            csr_we,
   input  logic [bmlb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bmlb_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bmlb_pkg::*;

   cfg_type cfg;
   rsp_type result;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    take;

   bmlb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign req_ch.ready = ~rsp_valid_ff | rsp_ch.ready;
   assign take         = req_ch.valid & req_ch.ready;

   bmlb_tick #(
      .NUM_DUTY_LEVELS (NUM_DUTY_LEVELS),
      .NUM_BLINK_MODES (NUM_BLINK_MODES)
   ) u_tick (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .buttons ({req_ch.button_d, req_ch.button_c, req_ch.button_b, req_ch.button_a}),
      .cfg     (cfg),
      .result  (result)
   );

   // hold valid until the beat is taken, reload on every accepted request
   assign rsp_valid_in = take | (rsp_valid_ff & ~rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.led_blink  = result.led_blink;
   assign rsp_ch.led_steady = result.led_steady;
   assign rsp_ch.led_asym   = result.led_asym;
   assign rsp_ch.led_pwm    = result.led_pwm;
   assign rsp_ch.blink_mode = result.blink_mode;
   assign rsp_ch.duty_level = result.duty_level;

endmodule

@@ sv/bmlb_csr.sv @@
// Configuration register file of the LED pattern block.
module bmlb_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [bmlb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bmlb_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output bmlb_pkg::cfg_type                   cfg
);
   import bmlb_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_SAMPLE_INTERVAL: cfg_in.sample_interval = csr_wdata;
            REG_HALF_PERIOD_0:   cfg_in.half_period_0   = csr_wdata;
            REG_HALF_PERIOD_1:   cfg_in.half_period_1   = csr_wdata;
            REG_HALF_PERIOD_2:   cfg_in.half_period_2   = csr_wdata;
            REG_HALF_PERIOD_3:   cfg_in.half_period_3   = csr_wdata;
            REG_ASYM_TOTAL:      cfg_in.asym_total      = csr_wdata;
            REG_PWM_PERIOD:      cfg_in.pwm_period      = csr_wdata[PERIOD_W-1:0];
            REG_DUTY_STEP:       cfg_in.duty_step       = csr_wdata[STEP_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_interval <= SAMPLE_INTERVAL_RST;
         cfg_ff.half_period_0   <= HALF_PERIOD_RST[0];
         cfg_ff.half_period_1   <= HALF_PERIOD_RST[1];
         cfg_ff.half_period_2   <= HALF_PERIOD_RST[2];
         cfg_ff.half_period_3   <= HALF_PERIOD_RST[3];
         cfg_ff.asym_total      <= ASYM_TOTAL_RST;
         cfg_ff.pwm_period      <= PWM_PERIOD_RST;
         cfg_ff.duty_step       <= DUTY_STEP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ sv/bmlb_tick.sv @@
// Per-tick state update: sampling, edge detect, LED timers and PWM.
module bmlb_tick #(
   parameter int NUM_DUTY_LEVELS = bmlb_pkg::NUM_DUTY_LEVELS_DEF,
   parameter int NUM_BLINK_MODES = bmlb_pkg::NUM_BLINK_MODES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [3:0]        buttons,
   input  bmlb_pkg::cfg_type cfg,
   output bmlb_pkg::rsp_type result
);
   import bmlb_pkg::*;

   localparam int DUTY_W = (NUM_DUTY_LEVELS > 1) ? $clog2(NUM_DUTY_LEVELS) : 1;
   localparam int WAIT_W = DUTY_W + STEP_W;

   logic [CNT_W-1:0]  sample_elapsed_ff, sample_elapsed_in;
   logic [3:0]        prev_buttons_ff, prev_buttons_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic              steady_ff, steady_in;
   logic [CNT_W-1:0]  phase_ff, phase_in;
   logic [DUTY_W-1:0] duty_ff, duty_in;
   logic [CNT_W-1:0]  blink_elapsed_ff, blink_elapsed_in;
   logic [CNT_W-1:0]  asym_elapsed_ff, asym_elapsed_in;
   logic [CNT_W-1:0]  pwm_elapsed_ff, pwm_elapsed_in;
   logic              led_a_ff, led_a_in;
   logic              led_c_ff, led_c_in;
   logic              led_d_ff, led_d_in;

   logic [CNT_W-1:0]  se_inc, be_inc, ae_inc, pe_inc;
   logic              sample;
   logic [3:0]        press;
   logic [CNT_W-1:0]  half;
   logic [CNT_W-1:0]  phase_diff;
   logic              phase_over;
   logic [CNT_W-1:0]  phase_now;
   logic [WAIT_W-1:0] duty_time;
   logic [CNT_W-1:0]  duty_wide;
   logic [CNT_W-1:0]  period_wide;
   logic [CNT_W-1:0]  wait_time;

   function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] v);
      return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
   endfunction

   always_comb begin
      se_inc = inc_sat(sample_elapsed_ff);
      be_inc = inc_sat(blink_elapsed_ff);
      ae_inc = inc_sat(asym_elapsed_ff);
      pe_inc = inc_sat(pwm_elapsed_ff);

      sample            = (se_inc >= cfg.sample_interval);
      press             = sample ? (buttons & ~prev_buttons_ff) : 4'b0000;
      prev_buttons_in   = sample ? buttons : prev_buttons_ff;
      sample_elapsed_in = sample ? '0 : se_inc;

      // LED A: mode steps first, the new mode picks the half period
      mode_in = mode_ff;
      if (press[0]) begin
         mode_in = (mode_ff == MODE_W'(NUM_BLINK_MODES - 1)) ? '0 : mode_ff + MODE_W'(1);
      end
      case (mode_in)
         2'd0:    half = cfg.half_period_0;
         2'd1:    half = cfg.half_period_1;
         2'd2:    half = cfg.half_period_2;
         default: half = cfg.half_period_3;
      endcase
      led_a_in         = led_a_ff;
      blink_elapsed_in = be_inc;
      if (be_inc >= half) begin
         led_a_in         = ~led_a_ff;
         blink_elapsed_in = '0;
      end

      // LED B
      steady_in = press[1] ? ~steady_ff : steady_ff;

      // LED C: a double swap lands on min(phase, total)
      phase_over = (phase_ff > cfg.asym_total);
      phase_diff = phase_over ? '0 : cfg.asym_total - phase_ff;
      phase_now  = press[2] ? phase_diff : phase_ff;
      led_c_in        = led_c_ff;
      asym_elapsed_in = ae_inc;
      phase_in        = phase_now;
      if (ae_inc >= phase_now) begin
         led_c_in        = ~led_c_ff;
         asym_elapsed_in = '0;
         if (press[2]) begin
            phase_in = phase_over ? cfg.asym_total : phase_ff;
         end else begin
            phase_in = phase_diff;
         end
      end

      // LED D: low waits duty time, high waits the rest of the period
      duty_in = duty_ff;
      if (press[3]) begin
         duty_in = (duty_ff == DUTY_W'(NUM_DUTY_LEVELS - 1)) ? '0 : duty_ff + DUTY_W'(1);
      end
      duty_time   = WAIT_W'(duty_in) * WAIT_W'(cfg.duty_step);
      duty_wide   = CNT_W'(duty_time);
      period_wide = CNT_W'(cfg.pwm_period);
      if (led_d_ff) begin
         wait_time = (period_wide > duty_wide) ? period_wide - duty_wide : '0;
      end else begin
         wait_time = duty_wide;
      end
      led_d_in       = led_d_ff;
      pwm_elapsed_in = pe_inc;
      if (pe_inc >= wait_time) begin
         led_d_in       = ~led_d_ff;
         pwm_elapsed_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_elapsed_ff <= '0;
         prev_buttons_ff   <= 4'b1111;
         mode_ff           <= '0;
         steady_ff         <= 1'b0;
         phase_ff          <= ASYM_PHASE_RST;
         duty_ff           <= '0;
         blink_elapsed_ff  <= '0;
         asym_elapsed_ff   <= '0;
         pwm_elapsed_ff    <= '0;
         led_a_ff          <= 1'b0;
         led_c_ff          <= 1'b0;
         led_d_ff          <= 1'b0;
      end else if (take) begin
         sample_elapsed_ff <= sample_elapsed_in;
         prev_buttons_ff   <= prev_buttons_in;
         mode_ff           <= mode_in;
         steady_ff         <= steady_in;
         phase_ff          <= phase_in;
         duty_ff           <= duty_in;
         blink_elapsed_ff  <= blink_elapsed_in;
         asym_elapsed_ff   <= asym_elapsed_in;
         pwm_elapsed_ff    <= pwm_elapsed_in;
         led_a_ff          <= led_a_in;
         led_c_ff          <= led_c_in;
         led_d_ff          <= led_d_in;
      end
   end

   // the state after the last beat is the result of that beat
   assign result.led_blink  = led_a_ff;
   assign result.led_steady = steady_ff;
   assign result.led_asym   = led_c_ff;
   assign result.led_pwm    = led_d_ff;
   assign result.blink_mode = mode_ff;
   assign result.duty_level = DUTY_OUT_W'(duty_ff);

endmodule

@@ sv/bmlb_checker.sv @@
// Port-level checker of the LED pattern block and its bind.
`include "button_mode_led_blink_pwm_core_defines.svh"

module bmlb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] blink_mode,
   input logic [2:0] duty_level
);

   `BMLB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `BMLB_ASSERT_NEXT(a_req_gives_rsp, clock, reset, req_valid && req_ready, rsp_valid)
   `BMLB_ASSERT_SAME(a_stall_blocks_req, clock, reset, rsp_valid && !rsp_ready, !req_ready)
   `BMLB_ASSERT_NEXT(a_mode_needs_beat, clock, reset, !(req_valid && req_ready),
                     $stable(blink_mode) && $stable(duty_level))

endmodule

bind button_mode_led_blink_pwm_core bmlb_checker u_bmlb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .blink_mode (rsp_ch.blink_mode),
   .duty_level (rsp_ch.duty_level)
);
